FILE: rtl/gpo_pkg.sv
`timescale 1ns / 1ps

package gpo_pkg;

   // counter width; the period register keeps its full 16 bits, only these are used
   localparam int COUNT_BITS = 16;

   // field widths
   localparam int OP_BITS       = 3;
   localparam int DUTY_IN_BITS  = 16;
   localparam int DUTY_BITS     = 15;
   localparam int PULSE_BITS    = 16;
   localparam int TOP_REG_BITS  = 16;
   localparam int TPU_BITS      = 8;
   localparam int OUT_CNT_BITS  = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   // shared multiplier: (top + 1) * duty or pulse_us * ticks_per_us
   localparam int MUL_A_BITS = (COUNT_BITS + 1 > PULSE_BITS) ? COUNT_BITS + 1 : PULSE_BITS;
   localparam int MUL_B_BITS = DUTY_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int Q_SHIFT    = 15;

   // duty ceiling saturation limits, 0.05 and 0.95 in Q0.15
   localparam logic [DUTY_BITS-1:0] DUTY_MIN_Q15 = 15'd1638;
   localparam logic [DUTY_BITS-1:0] DUTY_MAX_Q15 = 15'd31130;

   // register reset values
   localparam logic [TOP_REG_BITS-1:0] RST_PERIOD_TOP = 16'd255;
   localparam logic [DUTY_BITS-1:0]    RST_MAX_DUTY   = 15'd6554;
   localparam logic [TPU_BITS-1:0]     RST_TICKS_US   = 8'd8;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD_TOP   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_DUTY     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TICKS_PER_US = 2'd2;

   typedef enum logic [OP_BITS-1:0] {
      OP_TICK        = 3'd0,
      OP_SET_DUTY    = 3'd1,
      OP_ENABLE      = 3'd2,
      OP_ENABLE_WRAP = 3'd3,
      OP_DISABLE     = 3'd4,
      OP_ONESHOT     = 3'd5
   } op_type;

   typedef struct packed {
      logic [TOP_REG_BITS-1:0] period_top;
      logic [DUTY_BITS-1:0]    max_duty;
      logic [TPU_BITS-1:0]     ticks_per_us;
   } cfg_type;

   typedef struct packed {
      logic                    gate;
      logic [OUT_CNT_BITS-1:0] count;
      logic                    attached;
      logic                    oneshot_busy;
      logic [DUTY_BITS-1:0]    duty_applied;
      logic [OUT_CNT_BITS-1:0] compare_value;
   } status_type;

endpackage

FILE: rtl/gpo_csr.sv
`timescale 1ns / 1ps

module gpo_csr
   import gpo_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output cfg_type                  cfg
);

   cfg_type              cfg_ff, cfg_in;
   logic [DUTY_BITS-1:0] duty_wr;

   // ceiling writes saturate into the safe window
   always_comb begin
      duty_wr = csr_data[DUTY_BITS-1:0];
      if (duty_wr < DUTY_MIN_Q15) begin
         duty_wr = DUTY_MIN_Q15;
      end else if (duty_wr > DUTY_MAX_Q15) begin
         duty_wr = DUTY_MAX_Q15;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PERIOD_TOP:   cfg_in.period_top   = csr_data[TOP_REG_BITS-1:0];
            CSR_MAX_DUTY:     cfg_in.max_duty     = duty_wr;
            CSR_TICKS_PER_US: cfg_in.ticks_per_us = csr_data[TPU_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_top   <= RST_PERIOD_TOP;
         cfg_ff.max_duty     <= RST_MAX_DUTY;
         cfg_ff.ticks_per_us <= RST_TICKS_US;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/gpo_engine.sv
`timescale 1ns / 1ps

module gpo_engine
   import gpo_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [OP_BITS-1:0]      op,
   input  logic [DUTY_IN_BITS-1:0] duty_q15,
   input  logic [PULSE_BITS-1:0]   pulse_us,
   input  cfg_type                 cfg,
   output status_type              status
);

   logic [COUNT_BITS-1:0] counter_ff, counter_in;
   logic [COUNT_BITS-1:0] cmp_active_ff, cmp_active_in;
   logic [COUNT_BITS-1:0] cmp_buffer_ff, cmp_buffer_in;
   logic                  attach_ff, attach_in;
   logic                  pending_ff, pending_in;
   logic                  oneshot_ff, oneshot_in;
   logic                  armed_ff, armed_in;
   logic [DUTY_BITS-1:0]  duty_ff, duty_in;

   logic [COUNT_BITS-1:0]      top;
   logic [DUTY_BITS-1:0]       duty_clamped;
   logic                       is_set;
   logic [MUL_A_BITS-1:0]      mul_a;
   logic [MUL_B_BITS-1:0]      mul_b;
   logic [PROD_BITS-1:0]       product;
   logic [PROD_BITS-Q_SHIFT-1:0] cmp_full;
   logic [COUNT_BITS-1:0]      duty_cmp;
   logic [PROD_BITS-1:0]       ticks_lo;
   logic [COUNT_BITS-1:0]      ticks;

   assign top = cfg.period_top[COUNT_BITS-1:0];

   // duty request: negative to zero, then the ceiling
   always_comb begin
      duty_clamped = duty_q15[DUTY_IN_BITS-1] ? '0 : duty_q15[DUTY_BITS-1:0];
      if (duty_clamped > cfg.max_duty) begin
         duty_clamped = cfg.max_duty;
      end
   end

   // one multiplier shared by set duty and one-shot scaling
   assign is_set  = (op == OP_SET_DUTY);
   assign mul_a   = is_set ? (MUL_A_BITS'(top) + MUL_A_BITS'(1)) : MUL_A_BITS'(pulse_us);
   assign mul_b   = is_set ? duty_clamped : MUL_B_BITS'(cfg.ticks_per_us);
   assign product = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   // compare from duty, limited to top
   always_comb begin
      cmp_full = product[PROD_BITS-1:Q_SHIFT];
      duty_cmp = (cmp_full > (PROD_BITS-Q_SHIFT)'(top)) ? top : cmp_full[COUNT_BITS-1:0];
   end

   // one-shot length: at least one tick, at most top
   always_comb begin
      ticks_lo = (product == '0) ? PROD_BITS'(1) : product;
      ticks    = (ticks_lo > PROD_BITS'(top)) ? top : ticks_lo[COUNT_BITS-1:0];
   end

   // next state for the item in the input register
   always_comb begin
      counter_in    = counter_ff;
      cmp_active_in = cmp_active_ff;
      cmp_buffer_in = cmp_buffer_ff;
      attach_in     = attach_ff;
      pending_in    = pending_ff;
      oneshot_in    = oneshot_ff;
      armed_in      = armed_ff;
      duty_in       = duty_ff;
      unique case (op_type'(op))
         OP_TICK: begin
            if (counter_ff >= top) begin
               counter_in    = '0;
               cmp_active_in = cmp_buffer_ff;
               if (pending_ff) begin
                  attach_in  = 1'b1;
                  pending_in = 1'b0;
               end
            end else begin
               counter_in = counter_ff + COUNT_BITS'(1);
            end
            // first compare match ends the one-shot
            if (armed_ff && (counter_in == cmp_active_in)) begin
               attach_in  = 1'b0;
               oneshot_in = 1'b0;
               armed_in   = 1'b0;
            end
         end
         OP_SET_DUTY: begin
            duty_in       = duty_clamped;
            cmp_buffer_in = duty_cmp;
         end
         OP_ENABLE: begin
            attach_in  = 1'b1;
            pending_in = 1'b0;
         end
         OP_ENABLE_WRAP: begin
            if (!attach_ff) pending_in = 1'b1;
         end
         OP_DISABLE: begin
            attach_in  = 1'b0;
            pending_in = 1'b0;
            oneshot_in = 1'b0;
            armed_in   = 1'b0;
         end
         OP_ONESHOT: begin
            if (pulse_us != '0) begin
               cmp_buffer_in = ticks;
               oneshot_in    = 1'b1;
               armed_in      = 1'b1;
               if (!attach_ff) pending_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff    <= '0;
         cmp_active_ff <= '0;
         cmp_buffer_ff <= '0;
         attach_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         oneshot_ff    <= 1'b0;
         armed_ff      <= 1'b0;
         duty_ff       <= '0;
      end else if (step) begin
         counter_ff    <= counter_in;
         cmp_active_ff <= cmp_active_in;
         cmp_buffer_ff <= cmp_buffer_in;
         attach_ff     <= attach_in;
         pending_ff    <= pending_in;
         oneshot_ff    <= oneshot_in;
         armed_ff      <= armed_in;
         duty_ff       <= duty_in;
      end
   end

   // status after this item
   always_comb begin
      status.gate          = attach_in && (counter_in < cmp_active_in);
      status.count         = OUT_CNT_BITS'(counter_in);
      status.attached      = attach_in;
      status.oneshot_busy  = oneshot_in;
      status.duty_applied  = duty_in;
      status.compare_value = OUT_CNT_BITS'(cmp_active_in);
   end

   // one-shot flag and match arm always move together
   a_oneshot_armed: assert property (@(posedge clock) disable iff (reset)
      oneshot_ff == armed_ff)
      else $error("one-shot flag and match arm disagree");

   // a pending attach never coexists with an attached output
   a_pending_excl: assert property (@(posedge clock) disable iff (reset)
      !(attach_ff && pending_ff))
      else $error("attach pending while already attached");

   // disable leaves everything detached
   a_disable: assert property (@(posedge clock) disable iff (reset)
      (step && (op == OP_DISABLE)) |=> (!attach_ff && !pending_ff && !oneshot_ff))
      else $error("disable did not detach");

endmodule

FILE: rtl/gate_pwm_with_oneshot_core.sv
`timescale 1ns / 1ps

// Gate-drive PWM with duty ceiling and one-shot pulse.
// Request channel (req_valid / req_stall): one beat per command; req_op selects
// tick, set duty, enable, enable at wrap, disable or one-shot, with req_duty_q15
// and req_pulse_us as operands. Every request beat yields exactly one response
// beat (rsp_valid / rsp_stall) carrying gate level, counter, attach and one-shot
// status, applied duty and active compare value after that command.
// CSR port: csr_write_en with csr_index 0 period top, 1 duty ceiling (saturated
// to 0.05..0.95), 2 ticks per microsecond; write only while idle.
// Each request beat is held in one request register; then the state update and one
// shared multiplier feed the response register. Throughput is one beat per cycle
// while the response side is not stalled.
// A stalled response holds; the request register still takes one more beat, and
// req_stall rises only when both registers are full.
// Reset (synchronous, active high) clears counter, compares, flags and duty, and
// loads the registers with top 255, ceiling 0.20 and 8 ticks per microsecond.

module gate_pwm_with_oneshot_core
   import gpo_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_BITS-1:0]       req_op,
   input  logic [DUTY_IN_BITS-1:0]  req_duty_q15,
   input  logic [PULSE_BITS-1:0]    req_pulse_us,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_gate,
   output logic [OUT_CNT_BITS-1:0]  rsp_count,
   output logic                     rsp_attached,
   output logic                     rsp_oneshot_busy,
   output logic [DUTY_BITS-1:0]     rsp_duty_applied,
   output logic [OUT_CNT_BITS-1:0]  rsp_compare_value,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   cfg_type    cfg;
   status_type status;

   logic                    s1_valid_ff, s1_valid_in;
   logic [OP_BITS-1:0]      s1_op_ff;
   logic [DUTY_IN_BITS-1:0] s1_duty_ff;
   logic [PULSE_BITS-1:0]   s1_pulse_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_ff;
   logic                    advance;
   logic                    step;
   logic                    req_take;

   gpo_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   gpo_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .op       (s1_op_ff),
      .duty_q15 (s1_duty_ff),
      .pulse_us (s1_pulse_ff),
      .cfg      (cfg),
      .status   (status)
   );

   // pipeline control: the response register frees when empty or taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !advance);
      rsp_valid_in = step || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= req_op;
         s1_duty_ff  <= req_duty_q15;
         s1_pulse_ff <= req_pulse_us;
      end
      if (step) begin
         rsp_ff <= status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gate          = rsp_ff.gate;
   assign rsp_count         = rsp_ff.count;
   assign rsp_attached      = rsp_ff.attached;
   assign rsp_oneshot_busy  = rsp_ff.oneshot_busy;
   assign rsp_duty_applied  = rsp_ff.duty_applied;
   assign rsp_compare_value = rsp_ff.compare_value;

   // an empty request register never pushes back
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("request stalled with empty request register");

   // every processed beat shows up on the response side
   a_step_to_rsp: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed beat lost before response");

   // gate is only driven while attached
   a_gate_attached: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.gate || rsp_ff.attached))
      else $error("gate high while detached");

endmodule
